### hw/rtl/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W    = 11;   // register width
  localparam int SIZE_W   = 13;   // holds sizes up to 4096
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 10;

  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd320;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd240;

  // reciprocal of 3 for sums below 768: x*683 >> 11
  localparam logic [9:0] RECIP3     = 10'd683;
  localparam int         RECIP3_SH  = 11;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;   // row-major, entry 3*a+b
    logic [COORD_W-1:0]    row;
    logic [COORD_W-1:0]    col;
    logic                  last;
  } work_t;

endpackage
`default_nettype wire

### hw/rtl/sem_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       start_of_frame;
  modport source (output valid, red, green, blue, start_of_frame, input ready);
  modport sink   (input valid, red, green, blue, start_of_frame, output ready);
endinterface

interface edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_magnitude;
  logic [9:0] center_row;
  logic [9:0] center_column;
  logic       last_of_frame;
  modport source (output valid, edge_magnitude, center_row, center_column, last_of_frame,
                  input ready);
  modport sink   (input valid, edge_magnitude, center_row, center_column, last_of_frame,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// Front: one pixel at a time (line-store read, then window update and write-back); it
// waits while the queue is full. Back: one result at a time (gradient, squares, sum,
// bit-serial root, output held until taken); the root ends early when the magnitude saturates.
// A 2-entry queue lets the front take new pixels while the back is busy with results.
// Synchronous reset clears control, counters and window; line stores are not cleared.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [0:0]                wr_index,
  input  wire logic [sem_pkg::CFG_W-1:0] wr_data,
  pixel_if.sink                          pixel,
  edge_if.source                         edges
);
  logic [sem_pkg::CFG_W-1:0] image_width, image_height;
  sem_pkg::work_t f_data, b_data;
  logic f_push, f_ready, b_valid, b_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sem_pkg::RESET_WIDTH;
      image_height <= sem_pkg::RESET_HEIGHT;
    end else if (wr_en) begin
      case (wr_index)
        sem_pkg::REG_IMAGE_WIDTH:  image_width  <= wr_data;
        sem_pkg::REG_IMAGE_HEIGHT: image_height <= wr_data;
        default: ;
      endcase
    end
  end

  sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .image_width, .image_height, .pixel,
    .q_data(f_data), .q_push(f_push), .q_ready(f_ready)
  );

  sem_queue u_queue (
    .clk, .rst, .in_data(f_data), .push(f_push), .in_ready(f_ready),
    .out_data(b_data), .out_valid(b_valid), .pop(b_pop)
  );

  sem_back u_back (
    .clk, .rst, .q_data(b_data), .q_valid(b_valid), .q_pop(b_pop), .edges
  );

`ifndef SYNTH
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready |=> !pixel.ready)
    else $error("front took a transaction while busy");
  a_interior: assert property (@(posedge clk) disable iff (rst)
    edges.valid |-> edges.center_row != 10'd0 && edges.center_column != 10'd0)
    else $error("result on a border pixel");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_push |-> f_ready)
    else $error("queue overflow");
`endif
endmodule
`default_nettype wire

### hw/rtl/sem_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sem_front #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [sem_pkg::CFG_W-1:0]    image_width,
  input  wire logic [sem_pkg::CFG_W-1:0]    image_height,
  pixel_if.sink                             pixel,
  output sem_pkg::work_t                    q_data,
  output logic                              q_push,
  input  wire logic                         q_ready
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam logic [sem_pkg::SIZE_W-1:0] MAXW = sem_pkg::SIZE_W'(MAX_WIDTH);
  localparam logic [sem_pkg::SIZE_W-1:0] MAXH = sem_pkg::SIZE_W'(MAX_HEIGHT);
  localparam logic [sem_pkg::SIZE_W-1:0] MIN_SIZE = sem_pkg::SIZE_W'(3);

  typedef enum logic {S_IDLE, S_LOOK} state_t;
  state_t state;

  logic [sem_pkg::SIZE_W-1:0] w_eff, h_eff, wx, hx;
  logic [XW-1:0] col, cur_c, c_use;
  logic [YW-1:0] row, cur_r, r_use;
  logic [7:0]    gray, cur_gray, top, mid;
  logic [9:0]    csum;
  logic [19:0]   prod;
  logic [7:0]    win [3][3];
  logic [15:0]   lines [MAX_WIDTH];   // {upper, middle}
  logic [15:0]   rd_data;
  logic          accept, has_res, done;
  logic [sem_pkg::SIZE_W-1:0] c_ext, r_ext, c_inc, r_inc;
  logic [8:0][7:0] nwin;

  assign wx = {{(sem_pkg::SIZE_W-sem_pkg::CFG_W){1'b0}}, image_width};
  assign hx = {{(sem_pkg::SIZE_W-sem_pkg::CFG_W){1'b0}}, image_height};
  assign w_eff = (wx < MIN_SIZE) ? MIN_SIZE : ((wx > MAXW) ? MAXW : wx);
  assign h_eff = (hx < MIN_SIZE) ? MIN_SIZE : ((hx > MAXH) ? MAXH : hx);

  assign pixel.ready = (state == S_IDLE) && !rst;
  assign accept      = pixel.valid && pixel.ready;

  assign csum = {2'b00, pixel.red} + {2'b00, pixel.green} + {2'b00, pixel.blue};
  assign prod = csum * sem_pkg::RECIP3;
  assign gray = prod[sem_pkg::RECIP3_SH +: 8];

  always_comb begin
    r_use = pixel.start_of_frame ? '0 : row;
    if (sem_pkg::SIZE_W'(r_use) >= h_eff) r_use = '0;
    c_use = pixel.start_of_frame ? '0 : col;
  end

  assign top   = rd_data[15:8];
  assign mid   = rd_data[7:0];
  assign c_ext = sem_pkg::SIZE_W'(cur_c);
  assign r_ext = sem_pkg::SIZE_W'(cur_r);
  assign c_inc = c_ext + 1'b1;
  assign r_inc = r_ext + 1'b1;
  assign has_res = (cur_r >= YW'(2)) && (cur_c >= XW'(2)) && (c_ext < w_eff);
  assign done    = (state == S_LOOK) && (!has_res || q_ready);

  // window after this pixel shifts in
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nwin[3*a]   = win[a][1];
      nwin[3*a+1] = win[a][2];
    end
    nwin[2] = top;
    nwin[5] = mid;
    nwin[8] = cur_gray;
  end

  always_comb begin
    q_data.win  = nwin;
    q_data.row  = sem_pkg::COORD_W'(cur_r - 1'b1);
    q_data.col  = sem_pkg::COORD_W'(cur_c - 1'b1);
    q_data.last = (r_inc == h_eff) && (c_inc == w_eff);
  end
  assign q_push = done && has_res;

  always_ff @(posedge clk) begin
    if (accept) rd_data <= lines[c_use];
    if (done) lines[cur_c] <= {mid, cur_gray};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col   <= '0;
      row   <= '0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          win[a][b] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_r    <= r_use;
            cur_c    <= c_use;
            cur_gray <= gray;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (done) begin
            for (int a = 0; a < 3; a++)
              for (int b = 0; b < 3; b++)
                win[a][b] <= nwin[3*a+b];
            if (c_inc >= w_eff) begin
              col <= '0;
              row <= (r_inc >= h_eff) ? '0 : YW'(r_inc);
            end else begin
              col <= XW'(c_inc);
              row <= cur_r;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/sem_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sem_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  sem_pkg::work_t      in_data,
  input  wire logic           push,
  output logic                in_ready,
  output sem_pkg::work_t      out_data,
  output logic                out_valid,
  input  wire logic           pop
);
  sem_pkg::work_t slots [2];
  logic       wp, rp;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rp];

  always_ff @(posedge clk) begin
    if (push && in_ready) slots[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && in_ready) wp <= ~wp;
      if (pop && out_valid) rp <= ~rp;
      count <= count + 2'((push && in_ready) ? 1 : 0) - 2'((pop && out_valid) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/sem_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sem_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  sem_pkg::work_t  q_data,
  input  wire logic       q_valid,
  output logic            q_pop,
  edge_if.source          edges
);
  typedef enum logic [2:0] {S_IDLE, S_SQR, S_SUM, S_ROOT, S_OUT} state_t;
  state_t state;

  logic signed [11:0] gx, gy, gx_n, gy_n;
  logic [19:0] sqx, sqy;
  logic [20:0] total;
  logic [15:0] rem, res, bitv, trial;
  logic [2:0]  step;
  logic [9:0]  row, col;
  logic        last;

  function automatic logic signed [11:0] px(input logic [7:0] v);
    px = {4'b0000, v};
  endfunction

  always_comb begin
    gx_n = px(q_data.win[0]) - px(q_data.win[2]) + (px(q_data.win[3]) <<< 1)
         - (px(q_data.win[5]) <<< 1) + px(q_data.win[6]) - px(q_data.win[8]);
    gy_n = px(q_data.win[0]) + (px(q_data.win[1]) <<< 1) + px(q_data.win[2])
         - px(q_data.win[6]) - (px(q_data.win[7]) <<< 1) - px(q_data.win[8]);
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign trial = res + bitv;

  assign edges.valid          = (state == S_OUT);
  assign edges.edge_magnitude = res[7:0];
  assign edges.center_row     = row;
  assign edges.center_column  = col;
  assign edges.last_of_frame  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            gx    <= gx_n;
            gy    <= gy_n;
            row   <= q_data.row;
            col   <= q_data.col;
            last  <= q_data.last;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          sqx   <= 20'(gx * gx);
          sqy   <= 20'(gy * gy);
          state <= S_SUM;
        end
        S_SUM: begin
          total <= {1'b0, sqx} + {1'b0, sqy};
          state <= S_ROOT;
          rem   <= 16'(sqx + sqy);
          res   <= '0;
          bitv  <= 16'h4000;
          step  <= '0;
        end
        S_ROOT: begin
          // one result bit per cycle; a sum of 65536 or more saturates to 255 instead
          if (total[20:16] != 5'd0) begin
            res   <= 16'd255;
            state <= S_OUT;
          end else begin
            if (rem >= trial) begin
              rem <= rem - trial;
              res <= (res >> 1) + bitv;
            end else begin
              res <= res >> 1;
            end
            bitv <= bitv >> 2;
            step <= step + 1'b1;
            if (step == 3'd7) state <= S_OUT;
          end
        end
        S_OUT: begin
          if (edges.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### tb/sv/sobel_edge_magnitude_tb.sv
`timescale 1ns / 1ps
module sobel_edge_magnitude_tb;

  localparam int LIMIT   = 20000;  // cycles without any transaction
  localparam int SETTLE  = 20;     // front-to-back latency plus margin
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       sof;
  } pixel_t;

  typedef struct {
    logic [7:0] mag;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } edge_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [0:0] wr_index;
  logic [sem_pkg::CFG_W-1:0] wr_data;

  pixel_if pix_ch ();
  edge_if  edge_ch ();

  sobel_edge_magnitude i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixel    (pix_ch),
    .edges    (edge_ch)
  );

  pixel_t pending_pixels[$];
  edge_t  expected_edges[$];
  int     errors = 0;
  int     src_idle_pct = 0;
  int     sink_stall_pct = 0;
  bit     sender_hold = 0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  // shadow of the block
  logic [sem_pkg::CFG_W-1:0] width_reg = sem_pkg::RESET_WIDTH;
  logic [sem_pkg::CFG_W-1:0] height_reg = sem_pkg::RESET_HEIGHT;
  logic [7:0] upper_line[1024];
  logic [7:0] middle_line[1024];
  int     win[3][3];
  int     col_cnt = 0;
  int     row_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_size(int v);
    if (v < 3) return 3;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic int root_floor(int sum);
    int res;
    res = 0;
    while ((res + 1) * (res + 1) <= sum) res++;
    return res;
  endfunction

  task automatic predict_edge(pixel_t p);
    int w, h, gray, top, mid, gx, gy, sum;
    edge_t e;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    gray = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
    if (p.sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (row_cnt >= h) row_cnt = 0;
    top = upper_line[col_cnt];
    mid = middle_line[col_cnt];
    upper_line[col_cnt] = mid;
    middle_line[col_cnt] = gray;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = gray;
    if (row_cnt >= 2 && col_cnt >= 2 && col_cnt < w) begin
      gx = win[0][0] - win[0][2] + 2 * win[1][0] - 2 * win[1][2] + win[2][0] - win[2][2];
      gy = win[0][0] + 2 * win[0][1] + win[0][2] - win[2][0] - 2 * win[2][1] - win[2][2];
      sum = gx * gx + gy * gy;
      e.mag  = (sum >= 65536) ? 8'd255 : 8'(root_floor(sum));
      e.row  = 10'(row_cnt - 1);
      e.col  = 10'(col_cnt - 1);
      e.last = (row_cnt == h - 1 && col_cnt == w - 1);
      expected_edges.push_back(e);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (pending_pixels.size() > 0 && !sender_hold && $urandom_range(99) >= src_idle_pct) begin
        pixel_t p;
        p = pending_pixels.pop_front();
        pix_ch.valid <= 1'b1;
        pix_ch.red <= p.red;
        pix_ch.green <= p.green;
        pix_ch.blue <= p.blue;
        pix_ch.start_of_frame <= p.sof;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with its own long hold-off counter
  always @(posedge clk) begin
    if (rst) begin
      edge_ch.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      edge_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      edge_ch.ready <= 1'b0;
    end else begin
      edge_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) begin
        pixel_t p;
        p.red = pix_ch.red;
        p.green = pix_ch.green;
        p.blue = pix_ch.blue;
        p.sof = pix_ch.start_of_frame;
        predict_edge(p);
      end
      if (edge_ch.valid && edge_ch.ready) begin
        if (expected_edges.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual mag %0d row %0d col %0d",
                   $time, edge_ch.edge_magnitude, edge_ch.center_row, edge_ch.center_column);
          errors++;
        end else begin
          edge_t e;
          e = expected_edges.pop_front();
          check_field("edge_magnitude", e.mag, edge_ch.edge_magnitude);
          check_field("center_row", e.row, edge_ch.center_row);
          check_field("center_column", e.col, edge_ch.center_column);
          check_field("last_of_frame", e.last, edge_ch.last_of_frame);
        end
      end
      if ((pix_ch.valid && pix_ch.ready) || (edge_ch.valid && edge_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [sem_pkg::CFG_W-1:0] value);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    if (idx == sem_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic push_pixel(int r, int g, int b, bit sof);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.sof = sof;
    pending_pixels.push_back(p);
  endtask

  function automatic int rand_chan();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 255 : 0;
    return $urandom_range(255);
  endfunction

  // one frame in raster order; a truncated frame stops early
  task automatic push_frame(bit with_sof, bit truncate);
    int n;
    n = clamp_size(width_reg) * clamp_size(height_reg);
    if (truncate) n = $urandom_range(n - 1, 1);
    for (int i = 0; i < n; i++)
      push_pixel(rand_chan(), rand_chan(), rand_chan(), with_sof && i == 0);
  endtask

  // let everything drain, then wait out the pipeline
  task automatic drain();
    @(negedge clk);
    while (pending_pixels.size() > 0 || pix_ch.valid) @(negedge clk);
    while (expected_edges.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic random_phase(int src_pct, int sink_pct, int n_items, bit pressure);
    int sent;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    write_reg(sem_pkg::REG_IMAGE_WIDTH,
              $urandom_range(1) ? $urandom_range(8, 0) : $urandom_range(40, 3));
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, $urandom_range(7, 0));
    if (pressure) hold_requests++;
    // queue is empty here and no time passes while filling, so its size is the count
    push_frame(1'b1, 1'b0);
    sent = pending_pixels.size();
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: push_frame(1'b1, 1'b1);
        1: push_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
        2: push_frame(1'b0, 1'b0);   // wraps without start of frame
        default: push_frame(1'b1, 1'b0);
      endcase
      sent = pending_pixels.size();
    end
    if (pressure) begin
      // halfway through, stop sending until every result is out
      while (pending_pixels.size() > sent / 2) @(negedge clk);
      sender_hold = 1'b1;
      while (expected_edges.size() > 0 || pix_ch.valid) @(negedge clk);
      sender_hold = 1'b0;
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = sem_pkg::REG_IMAGE_WIDTH;
    wr_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.red = '0;
    pix_ch.green = '0;
    pix_ch.blue = '0;
    pix_ch.start_of_frame = 1'b0;
    edge_ch.ready = 1'b0;
    for (int k = 0; k < 1024; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) win[a][b] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: flat white, hard vertical edge, then clamped sizes with wrap
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd3);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) push_pixel(255, 255, 255, i == 0);
    for (int i = 0; i < 9; i++)
      if (i % 3 == 0) push_pixel(255, 255, 255, i == 0);
      else push_pixel(0, 0, 0, 1'b0);
    drain();
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd0);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd2);
    for (int i = 0; i < 9; i++) push_pixel(i < 3 ? 255 : 0, i * 28, 255 - i * 28, i == 0);
    push_pixel(0, 255, 255, 1'b0);
    drain();

    // register values above range, on the start of very wide and very tall frames
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd2047);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd3);
    for (int i = 0; i < 40; i++) push_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
    drain();
    write_reg(sem_pkg::REG_IMAGE_WIDTH, 11'd3);
    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 11'd2047);
    for (int i = 0; i < 60; i++) push_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
    drain();

    random_phase(0, 0, 80, 1'b0);
    random_phase(85, 0, 70, 1'b0);
    random_phase(0, 85, 70, 1'b1);
    random_phase(25, 25, 80, 1'b1);

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sem_pkg.sv
hw/rtl/sem_if.sv
hw/rtl/sem_front.sv
hw/rtl/sem_queue.sv
hw/rtl/sem_back.sv
hw/rtl/sobel_edge_magnitude.sv
tb/sv/sobel_edge_magnitude_tb.sv
